// File: design/pan_pkg.sv
// Package for the panel area and normal unit: default sizes and fixed field widths.
// Has no dependencies; every module of the unit imports it.
`default_nettype none
package pan_pkg;
    localparam int P_COORD_BITS  = 24;
    localparam int P_NORMAL_BITS = 16;
    localparam int AREA_BITS     = 49;
endpackage
`default_nettype wire

// File: design/panel_area_and_normal_unit.sv
// Top level of the panel area and normal unit: cross product, squares, root, divide.
// Instantiates pan_sqrt and pan_div; uses pan_pkg.
//
// The unit takes one panel beat per clock while it is not stalled and returns its area
// and unit normal from the output register: seven stages form the diagonals, cross
// product and sum of squares, the square root takes one stage per root bit, the
// divider one stage per normal bit, and one output register follows. All stages move
// together; while an output beat waits and i_stall is high the whole pipeline holds
// and o_stall is raised.
`default_nettype none
module panel_area_and_normal_unit #(
    parameter int COORD_BITS  = pan_pkg::P_COORD_BITS,
    parameter int NORMAL_BITS = pan_pkg::P_NORMAL_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_BITS-1:0]  i_v0_x,
    input  wire logic signed [COORD_BITS-1:0]  i_v0_y,
    input  wire logic signed [COORD_BITS-1:0]  i_v0_z,
    input  wire logic signed [COORD_BITS-1:0]  i_v1_x,
    input  wire logic signed [COORD_BITS-1:0]  i_v1_y,
    input  wire logic signed [COORD_BITS-1:0]  i_v1_z,
    input  wire logic signed [COORD_BITS-1:0]  i_v2_x,
    input  wire logic signed [COORD_BITS-1:0]  i_v2_y,
    input  wire logic signed [COORD_BITS-1:0]  i_v2_z,
    input  wire logic signed [COORD_BITS-1:0]  i_v3_x,
    input  wire logic signed [COORD_BITS-1:0]  i_v3_y,
    input  wire logic signed [COORD_BITS-1:0]  i_v3_z,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [pan_pkg::AREA_BITS-1:0]      o_area,
    output logic signed [NORMAL_BITS-1:0]      o_normal_x,
    output logic signed [NORMAL_BITS-1:0]      o_normal_y,
    output logic signed [NORMAL_BITS-1:0]      o_normal_z,
    output logic                               o_degenerate
);
    import pan_pkg::*;

    localparam int D      = COORD_BITS + 1;
    localparam int PW     = 2 * D;
    localparam int SW     = 2 * D + 1;
    localparam int UW     = 2 * D;
    localparam int H      = (UW + 1) / 2;
    localparam int HW     = UW - H;
    localparam int SQW    = 2 * UW;
    localparam int RW     = UW + 1;
    localparam int SUMW   = 2 * RW;
    localparam int SIDE_W = 3 * UW + 3;
    localparam int NB     = NORMAL_BITS;
    localparam int CW     = (RW > AREA_BITS) ? RW : AREA_BITS + 1;
    localparam logic [NB-1:0]        ONE      = {1'b1, {(NB-1){1'b0}}};
    localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

    logic en;

    logic                r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic signed [D-1:0]  r_a [0:2];
    logic signed [D-1:0]  r_b [0:2];
    logic signed [PW-1:0] r_p [0:5];
    logic signed [SW-1:0] r_s [0:2];
    logic [SIDE_W-1:0]    r_side4, r_side5, r_side6, r_side7;
    logic [2*HW-1:0]      r_hh [0:2];
    logic [UW-1:0]        r_hl [0:2];
    logic [2*H-1:0]       r_ll [0:2];
    logic [SQW-1:0]       r_sq [0:2];
    logic [SUMW-1:0]      r_sum;

    logic              sq_valid;
    logic [RW-1:0]     sq_root;
    logic [SIDE_W-1:0] sq_side;
    logic              dv_valid;
    logic [RW-1:0]     dv_m;
    logic [3*NB-1:0]   dv_q;
    logic [2:0]        dv_neg;
    logic [NB-1:0]     nrm [0:2];
    logic [CW-1:0]     half_w;

    logic                 r_out_valid;
    logic [AREA_BITS-1:0] r_area;
    logic [NB-1:0]        r_nrm [0:2];
    logic                 r_deg;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a[0] <= D'(i_v2_x) - D'(i_v0_x);
            r_a[1] <= D'(i_v2_y) - D'(i_v0_y);
            r_a[2] <= D'(i_v2_z) - D'(i_v0_z);
            r_b[0] <= D'(i_v3_x) - D'(i_v1_x);
            r_b[1] <= D'(i_v3_y) - D'(i_v1_y);
            r_b[2] <= D'(i_v3_z) - D'(i_v1_z);

            r_p[0] <= r_a[1] * r_b[2];
            r_p[1] <= r_a[2] * r_b[1];
            r_p[2] <= r_a[2] * r_b[0];
            r_p[3] <= r_a[0] * r_b[2];
            r_p[4] <= r_a[0] * r_b[1];
            r_p[5] <= r_a[1] * r_b[0];

            r_s[0] <= SW'(r_p[0]) - SW'(r_p[1]);
            r_s[1] <= SW'(r_p[2]) - SW'(r_p[3]);
            r_s[2] <= SW'(r_p[4]) - SW'(r_p[5]);

            r_side5 <= r_side4;
            r_side6 <= r_side5;
            r_side7 <= r_side6;

            r_sum <= SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
        logic [UW-1:0] u5;

        assign u5 = r_side4[j*UW +: UW];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side4[j*UW +: UW] <= r_s[j][SW-1] ? UW'(-r_s[j]) : UW'(r_s[j]);
                r_side4[3*UW + j]   <= r_s[j][SW-1];

                r_hh[j] <= u5[UW-1:H] * u5[UW-1:H];
                r_hl[j] <= u5[UW-1:H] * u5[H-1:0];
                r_ll[j] <= u5[H-1:0] * u5[H-1:0];

                r_sq[j] <= (SQW'(r_hh[j]) << (2 * H)) + (SQW'(r_hl[j]) << (H + 1))
                         + SQW'(r_ll[j]);
            end
        end
    end

    pan_sqrt #(
        .RW     (RW),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v7),
        .i_rad   (r_sum),
        .i_side  (r_side7),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    pan_div #(
        .RW (RW),
        .UW (UW),
        .NB (NB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_m     (sq_root),
        .i_u     (sq_side[3*UW-1:0]),
        .i_neg   (sq_side[SIDE_W-1 -: 3]),
        .o_valid (dv_valid),
        .o_m     (dv_m),
        .o_q     (dv_q),
        .o_neg   (dv_neg)
    );

    for (genvar j = 0; j < 3; j++) begin : g_fix
        logic [NB-1:0] q;
        logic [NB-1:0] qc;

        assign q  = dv_q[j*NB +: NB];
        assign qc = (q > ONE) ? ONE : q;

        always_comb begin
            if (dv_m == '0) begin
                nrm[j] = '0;
            end else if (dv_neg[j]) begin
                nrm[j] = NB'(-qc);
            end else if (qc == ONE) begin
                nrm[j] = ONE - NB'(1);
            end else begin
                nrm[j] = qc;
            end
        end
    end

    assign half_w = CW'(dv_m) >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_area   <= (half_w > CW'(AREA_MAX)) ? AREA_MAX : AREA_BITS'(half_w);
            r_nrm[0] <= nrm[0];
            r_nrm[1] <= nrm[1];
            r_nrm[2] <= nrm[2];
            r_deg    <= (dv_m == '0);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_area       = r_area;
    assign o_normal_x   = r_nrm[0];
    assign o_normal_y   = r_nrm[1];
    assign o_normal_z   = r_nrm[2];
    assign o_degenerate = r_deg;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow the output register");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
        (o_area == '0 && o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0))
        else $error("degenerate beat carries a non-zero area or normal");

    a_normal_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_degenerate) |->
        (o_normal_x != '0 || o_normal_y != '0 || o_normal_z != '0))
        else $error("non-degenerate beat has a zero normal");
endmodule
`default_nettype wire

// File: design/pan_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries a side payload alongside the radicand; uses pan_pkg.
`default_nettype none
module pan_sqrt #(
    parameter int RW     = pan_pkg::P_COORD_BITS * 2 + 3,
    parameter int SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [2*RW-1:0]   i_rad,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [RW-1:0]          o_root,
    output logic [SIDE_W-1:0]      o_side
);
    import pan_pkg::*;

    logic              r_v    [1:RW];
    logic [RW-1:0]     r_root [1:RW];
    logic [SIDE_W-1:0] r_side [1:RW];
    logic [RW:0]       r_rem  [1:RW];
    logic [2*RW-1:0]   r_rad  [1:RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic              v_in;
        logic [RW:0]       rem_in;
        logic [RW-1:0]     root_in;
        logic [2*RW-1:0]   rad_in;
        logic [SIDE_W-1:0] side_in;
        logic [RW+2:0]     sh;
        logic [RW+2:0]     trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k];
            assign rem_in  = r_rem[k];
            assign root_in = r_root[k];
            assign rad_in  = r_rad[k];
            assign side_in = r_side[k];
        end

        assign sh    = {rem_in, rad_in[2*(RW-1-k)+1 -: 2]};
        assign trial = (RW+3)'({root_in, 2'b01});
        assign ge    = (sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k+1] <= {root_in[RW-2:0], ge};
                r_side[k+1] <= side_in;
                r_rem[k+1]  <= ge ? (RW+1)'(sh - trial) : (RW+1)'(sh);
                r_rad[k+1]  <= rad_in;
            end
        end
    end

    assign o_valid = r_v[RW];
    assign o_root  = r_root[RW];
    assign o_side  = r_side[RW];
endmodule
`default_nettype wire

// File: design/pan_div.sv
// Pipelined restoring divider for the three normal lanes, one quotient bit per stage.
// Divides each magnitude by the common root; uses pan_pkg.
`default_nettype none
module pan_div #(
    parameter int RW = pan_pkg::P_COORD_BITS * 2 + 3,
    parameter int UW = pan_pkg::P_COORD_BITS * 2 + 2,
    parameter int NB = pan_pkg::P_NORMAL_BITS
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [RW-1:0]   i_m,
    input  wire logic [3*UW-1:0] i_u,
    input  wire logic [2:0]      i_neg,
    output logic                 o_valid,
    output logic [RW-1:0]        o_m,
    output logic [3*NB-1:0]      o_q,
    output logic [2:0]           o_neg
);
    import pan_pkg::*;

    logic          r_v   [1:NB];
    logic [RW-1:0] r_m   [1:NB];
    logic [2:0]    r_neg [1:NB];
    logic [RW-1:0] r_r   [1:NB][0:2];
    logic [NB-1:0] r_q   [1:NB][0:2];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic          v_in;
        logic [RW-1:0] m_in;
        logic [2:0]    neg_in;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign m_in   = i_m;
            assign neg_in = i_neg;
        end else begin : g_next
            assign v_in   = r_v[k];
            assign m_in   = r_m[k];
            assign neg_in = r_neg[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k+1]   <= m_in;
                r_neg[k+1] <= neg_in;
            end
        end

        for (genvar j = 0; j < 3; j++) begin : g_lane
            logic [RW:0]   cand;
            logic [NB-1:0] q_in;
            logic          ge;

            if (k == 0) begin : g_first
                assign cand = (RW+1)'(i_u[j*UW +: UW]);
                assign q_in = '0;
            end else begin : g_next
                assign cand = {r_r[k][j], 1'b0};
                assign q_in = r_q[k][j];
            end

            assign ge = (cand >= (RW+1)'(m_in));

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_r[k+1][j] <= ge ? RW'(cand - (RW+1)'(m_in)) : RW'(cand);
                    r_q[k+1][j] <= {q_in[NB-2:0], ge};
                end
            end
        end
    end

    assign o_valid = r_v[NB];
    assign o_m     = r_m[NB];
    assign o_neg   = r_neg[NB];
    for (genvar j = 0; j < 3; j++) begin : g_out
        assign o_q[j*NB +: NB] = r_q[NB][j];
    end
endmodule
`default_nettype wire

// File: test/tb_panel_area_and_normal_unit.sv
// Testbench for panel_area_and_normal_unit: drives panel corner beats with random idling
// and stalls, and checks area, unit normal and degenerate flag against a behavioural predictor.
// Depends on pan_pkg and the unit itself.
`default_nettype none
module tb_panel_area_and_normal_unit;
    import pan_pkg::*;

    localparam int CB = P_COORD_BITS;
    localparam int NB = P_NORMAL_BITS;
    localparam int N_DIRECTED = 14;
    localparam int N_RANDOM = 1150;

    typedef logic signed [CB-1:0] coord_t;
    typedef struct packed {
        logic [AREA_BITS-1:0] area;
        logic signed [NB-1:0] nx;
        logic signed [NB-1:0] ny;
        logic signed [NB-1:0] nz;
        logic                 degen;
    } panel_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    coord_t crn [12];
    logic o_stall, o_valid, o_degenerate;
    logic [AREA_BITS-1:0] o_area;
    logic signed [NB-1:0] o_normal_x, o_normal_y, o_normal_z;

    panel_res_t pending_faces [$];
    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int degen_seen = 0;
    bit quiet = 1'b0;

    always #4 i_clk = ~i_clk;

    panel_area_and_normal_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_v0_x(crn[0]), .i_v0_y(crn[1]), .i_v0_z(crn[2]),
        .i_v1_x(crn[3]), .i_v1_y(crn[4]), .i_v1_z(crn[5]),
        .i_v2_x(crn[6]), .i_v2_y(crn[7]), .i_v2_z(crn[8]),
        .i_v3_x(crn[9]), .i_v3_y(crn[10]), .i_v3_z(crn[11]),
        .o_valid(o_valid), .i_stall(i_stall), .o_area(o_area),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_degenerate(o_degenerate)
    );

    function automatic logic [63:0] isqrt128(logic [127:0] n);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= n) root = cand;
        end
        return root;
    endfunction

    function automatic logic signed [NB-1:0] unit_comp(logic signed [63:0] s,
                                                     logic [63:0] m);
        logic [127:0] q;
        logic [63:0] mag;
        logic [63:0] one;
        one = 64'd1 << (NB - 1);
        mag = s[63] ? -s : s;
        q = ({64'd0, mag} << (NB - 1)) / {64'd0, m};
        if (q > one) q = one;
        if (s[63]) return -q[NB-1:0];
        if (q == one) q = one - 1;
        return q[NB-1:0];
    endfunction

    function automatic panel_res_t face_of(coord_t c [12]);
        logic signed [63:0] ax, ay, az, bx, by, bz, sx, sy, sz;
        logic [63:0] ux, uy, uz, m;
        logic [127:0] sq;
        panel_res_t r;
        ax = 64'(c[6]) - 64'(c[0]);
        ay = 64'(c[7]) - 64'(c[1]);
        az = 64'(c[8]) - 64'(c[2]);
        bx = 64'(c[9]) - 64'(c[3]);
        by = 64'(c[10]) - 64'(c[4]);
        bz = 64'(c[11]) - 64'(c[5]);
        sx = ay * bz - az * by;
        sy = az * bx - ax * bz;
        sz = ax * by - ay * bx;
        ux = sx[63] ? -sx : sx;
        uy = sy[63] ? -sy : sy;
        uz = sz[63] ? -sz : sz;
        sq = {64'd0, ux} * {64'd0, ux} + {64'd0, uy} * {64'd0, uy}
           + {64'd0, uz} * {64'd0, uz};
        m = isqrt128(sq);
        r.area = ((m >> 1) > {15'd0, {AREA_BITS{1'b1}}}) ? '1 : AREA_BITS'(m >> 1);
        r.degen = (m == 0);
        if (m == 0) begin
            r.nx = '0;
            r.ny = '0;
            r.nz = '0;
        end else begin
            r.nx = unit_comp(sx, m);
            r.ny = unit_comp(sy, m);
            r.nz = unit_comp(sz, m);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on beat %0d: %s got %0h expected %0h", beats_out, what, got, want);
        errors++;
    endtask

    // Result side: random stall, compare against oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_faces.size() == 0) begin
                report_mismatch("unexpected beat", 0, 0);
            end else begin
                panel_res_t w;
                w = pending_faces.pop_front();
                if (o_area !== w.area) report_mismatch("area", o_area, w.area);
                if (o_normal_x !== w.nx) report_mismatch("normal_x", o_normal_x, w.nx);
                if (o_normal_y !== w.ny) report_mismatch("normal_y", o_normal_y, w.ny);
                if (o_normal_z !== w.nz) report_mismatch("normal_z", o_normal_z, w.nz);
                if (o_degenerate !== w.degen)
                    report_mismatch("degenerate", o_degenerate, w.degen);
                if (w.degen) degen_seen++;
            end
            beats_out++;
        end
        i_stall <= quiet ? 1'b0 : ($urandom_range(99) < 19);
    end

    function automatic coord_t rnd_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom_range(1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}});
            1: return coord_t'($urandom_range(15)) - 8;
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_panel(coord_t c [12], bit check_fixed, panel_res_t fixed);
        panel_res_t p;
        p = face_of(c);
        if (check_fixed && p !== fixed)
            report_mismatch("predictor against typed value", p.area, fixed.area);
        while (!quiet && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        for (int k = 0; k < 12; k++) crn[k] <= c[k];
        i_valid <= 1'b1;
        pending_faces.push_back(check_fixed ? fixed : p);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_in++;
    endtask

    localparam coord_t CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(CB-1){1'b0}}};
    localparam coord_t ONE = coord_t'(1 << 12);
    localparam logic signed [NB-1:0] NPOS = {1'b0, {(NB-1){1'b1}}};
    localparam logic signed [NB-1:0] NNEG = {1'b1, {(NB-1){1'b0}}};

    coord_t dir_crn [N_DIRECTED][12];
    panel_res_t dir_want [N_DIRECTED];
    bit dir_fixed [N_DIRECTED];

    initial begin
        coord_t c [12];
        for (int k = 0; k < 12; k++) crn[k] = '0;
        for (int r = 0; r < N_DIRECTED; r++) begin
            dir_fixed[r] = 1'b0;
            for (int k = 0; k < 12; k++) dir_crn[r][k] = '0;
        end
        // All corners at the origin: degenerate.
        dir_fixed[0] = 1'b1; dir_want[0] = '{0, 0, 0, 0, 1'b1};
        // Unit square in the xy plane: area 1, normal +z saturated.
        dir_crn[1] = '{0, 0, 0, ONE, 0, 0, ONE, ONE, 0, 0, ONE, 0};
        dir_fixed[1] = 1'b1; dir_want[1] = '{49'd1 << 24, 0, 0, NPOS, 1'b0};
        // Same square wound the other way: normal exactly -1.
        dir_crn[2] = '{0, 0, 0, 0, ONE, 0, ONE, ONE, 0, ONE, 0, 0};
        dir_fixed[2] = 1'b1; dir_want[2] = '{49'd1 << 24, 0, 0, NNEG, 1'b0};
        // Triangle given with the first corner repeated.
        dir_crn[3] = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, 0};
        dir_fixed[3] = 1'b1; dir_want[3] = '{49'd1 << 23, 0, 0, NPOS, 1'b0};
        // Square in yz and zx planes.
        dir_crn[4] = '{0, 0, 0, 0, ONE, 0, 0, ONE, ONE, 0, 0, ONE};
        dir_fixed[4] = 1'b1; dir_want[4] = '{49'd1 << 24, NPOS, 0, 0, 1'b0};
        dir_crn[5] = '{0, 0, 0, 0, 0, ONE, ONE, 0, ONE, ONE, 0, 0};
        dir_fixed[5] = 1'b1; dir_want[5] = '{49'd1 << 24, 0, NPOS, 0, 1'b0};
        // Collinear corners: degenerate.
        dir_crn[6] = '{0, 0, 0, ONE, ONE, ONE, CMAX, CMAX, CMAX, 5, 5, 5};
        dir_fixed[6] = 1'b1; dir_want[6] = '{0, 0, 0, 0, 1'b1};
        // Extreme and small corners, checked against the predictor; equal corners typed as degenerate.
        dir_crn[7] = '{CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN};
        dir_crn[8] = '{CMIN, 0, CMIN, 0, CMIN, CMIN, CMAX, 0, CMAX, 0, CMAX, CMAX};
        dir_crn[9] = '{CMAX, CMIN, 0, CMIN, CMAX, 0, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN};
        dir_crn[10] = '{-1, -1, -1, 1, 0, 0, 0, 1, 0, 0, 0, 1};
        dir_crn[11] = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                        CMAX, CMAX, CMAX};
        dir_fixed[11] = 1'b1; dir_want[11] = '{0, 0, 0, 0, 1'b1};
        dir_crn[12] = '{CMIN, CMIN, 0, CMAX, CMIN, 0, CMAX, CMAX, 0, CMIN, CMAX, 0};
        dir_crn[13] = '{1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < N_DIRECTED; r++)
            send_panel(dir_crn[r], dir_fixed[r], dir_want[r]);
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= 400 && n < 600);
            for (int k = 0; k < 12; k++) c[k] = rnd_coord();
            case ($urandom_range(9))
                0: for (int k = 9; k < 12; k++) c[k] = c[k - 9];
                1: for (int k = 6; k < 9; k++) c[k] = c[k - 6];
                2: for (int k = 3; k < 12; k++) c[k] = c[k % 3] + coord_t'($urandom_range(3));
                default: ;
            endcase
            send_panel(c, 1'b0, '0);
        end
        i_valid <= 1'b0;
        quiet = 1'b0;
        while (pending_faces.size() != 0) @(posedge i_clk);
        repeat (2 * CB + NB + 20) @(posedge i_clk);
        $display("%0d panels sent, %0d results checked, %0d degenerate.",
                 beats_in, beats_out, degen_seen);
        $display("Directed extremes, triangles and saturation cases, then random panels.");
        if (errors == 0 && pending_faces.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
